// ----- rtl/bole_pkg.sv -----
// Shared constants, types and helpers of the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  // List capacity in slots; the null link is the value CAPACITY itself.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int SLOT_W   = $clog2(CAPACITY + 1);

  // Beat field widths.
  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  // Width for comparing a position against the entry count.
  localparam int CMP_W = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;

  // Response status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Steps the controller asks the datapath to perform.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_ACCEPT,
    CMD_DECODE,
    CMD_REJECT,
    CMD_I_POP,
    CMD_WALK_START,
    CMD_WALK_STEP,
    CMD_I_RDN,
    CMD_I_W1,
    CMD_I_W2,
    CMD_D_RD,
    CMD_D_W1,
    CMD_D_W2
  } cmd_t;

  typedef enum logic [1:0] {
    DEC_REJ,
    DEC_INS,
    DEC_DEL
  } dec_kind_t;

  // Status returned from the datapath to the controller.
  typedef struct packed {
    dec_kind_t kind;
    logic      dec_walk;
    logic      hops_zero;
    logic      init_last;
  } dp_status_t;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return s < NULL_SLOT;
  endfunction

  function automatic logic [IDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bole_if.sv -----
// Request and response channel interfaces of the bounded ordered list engine.
`default_nettype none

interface bole_req_if;
  import bole_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [OP_W-1:0]  operation;
  logic        [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface bole_rsp_if;
  import bole_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [ST_W-1:0]  status;
  logic        [LEN_W-1:0] length;
  logic signed [VAL_W-1:0] removed_value;

  modport source (output valid, status, length, removed_value, input ready);
  modport sink   (input valid, status, length, removed_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/bole_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bole_dp.sv -----
// Datapath: link and value memories, list pointers, request decode and result register.
`default_nettype none

module bole_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bole_pkg::cmd_t                   cmd,
  input  wire logic        [bole_pkg::OP_W-1:0]  in_operation,
  input  wire logic        [bole_pkg::POS_W-1:0] in_position,
  input  wire logic signed [bole_pkg::VAL_W-1:0] in_value,
  output      bole_pkg::dp_status_t             sts,
  output      logic        [bole_pkg::ST_W-1:0]  res_status,
  output      logic        [bole_pkg::LEN_W-1:0] res_length,
  output      logic signed [bole_pkg::VAL_W-1:0] res_removed
);
  import bole_pkg::*;

  // List pointers and free chain.
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] free_s;
  logic [SLOT_W-1:0] count;
  logic [IDX_W-1:0]  init_idx;

  // Latched request.
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  // Working registers of one request.
  logic [SLOT_W-1:0] anchor;
  logic [SLOT_W-1:0] fresh;
  logic [SLOT_W-1:0] nbr_n;
  logic [IDX_W-1:0]  hops;

  // Memory ports.
  logic              nx_we, nx_re, pv_we, pv_re, vs_we, vs_re;
  logic [IDX_W-1:0]  nx_waddr, nx_raddr, pv_waddr, pv_raddr, vs_waddr, vs_raddr;
  logic [SLOT_W-1:0] nx_wdata, nx_q, pv_wdata, pv_q;
  logic [VAL_W-1:0]  vs_wdata, vs_q;

  // Decode results.
  dec_kind_t         dec_kind;
  logic [ST_W-1:0]   dec_status;
  logic [SLOT_W-1:0] dec_anchor;
  logic [IDX_W-1:0]  dec_hops;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              full;
  logic              pos_bad;
  logic [SLOT_W-1:0] n_new;

  bole_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_q)
  );

  bole_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(pv_re), .raddr(pv_raddr), .rdata(pv_q)
  );

  bole_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
    .re(vs_re), .raddr(vs_raddr), .rdata(vs_q)
  );

  assign pos_c = CMP_W'(pos_r);
  assign cnt_c = CMP_W'(count);
  assign full  = (count >= NULL_SLOT) || !slot_ok(free_s);

  // Request decode: outcome class, anchor slot and the number of hops to walk.
  always_comb begin
    dec_kind   = DEC_REJ;
    dec_status = ST_BADPOS;
    dec_anchor = NULL_SLOT;
    dec_hops   = '0;
    pos_bad    = 1'b0;
    unique case (op_r) inside
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        if (op_r == OP_INS_TAIL) begin
          dec_anchor = tail;
        end else if (op_r == OP_INS_POS && count != '0) begin
          if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
            pos_bad = 1'b1;
          end else if (pos_c > CMP_W'(1)) begin
            dec_anchor = head;
            dec_hops   = IDX_W'(pos_c - CMP_W'(2));
          end
        end
        if (pos_bad) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind   = DEC_INS;
          dec_status = ST_OK;
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
        dec_anchor = (op_r == OP_DEL_TAIL) ? tail : head;
        if (op_r == OP_DEL_POS) begin
          pos_bad  = (pos_c == '0) || (pos_c > cnt_c);
          dec_hops = IDX_W'(pos_c - CMP_W'(1));
        end
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else if (pos_bad) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_kind   = DEC_DEL;
          dec_status = ST_OK;
        end
      end
      default: begin
        dec_status = ST_BADPOS;
      end
    endcase
  end

  assign sts.kind      = dec_kind;
  assign sts.dec_walk  = (dec_hops != '0);
  assign sts.hops_zero = (hops == '0);
  assign sts.init_last = (init_idx == IDX_W'(CAPACITY - 1));

  // Successor of the new entry: the anchor's old successor, or the old head.
  assign n_new = slot_ok(anchor) ? nx_q : head;

  // Memory port control per step.
  always_comb begin
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_re = 1'b0; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_re = 1'b0; pv_raddr = '0;
    vs_we = 1'b0; vs_waddr = '0; vs_wdata = '0; vs_re = 1'b0; vs_raddr = '0;
    unique case (cmd) inside
      CMD_INIT: begin
        nx_we    = 1'b1;
        nx_waddr = init_idx;
        nx_wdata = SLOT_W'(init_idx) + SLOT_W'(1);
      end
      CMD_DECODE: begin
        nx_re    = 1'b1;
        nx_raddr = slot_idx(free_s);
      end
      CMD_WALK_START, CMD_I_RDN: begin
        nx_re    = 1'b1;
        nx_raddr = slot_idx(anchor);
      end
      CMD_WALK_STEP: begin
        nx_re    = (hops != '0);
        nx_raddr = slot_idx(nx_q);
      end
      CMD_I_W1: begin
        vs_we    = 1'b1;
        vs_waddr = slot_idx(fresh);
        vs_wdata = val_r;
        pv_we    = 1'b1;
        pv_waddr = slot_idx(fresh);
        pv_wdata = anchor;
        nx_we    = 1'b1;
        nx_waddr = slot_idx(fresh);
        nx_wdata = n_new;
      end
      CMD_I_W2: begin
        nx_we    = slot_ok(anchor);
        nx_waddr = slot_idx(anchor);
        nx_wdata = fresh;
        pv_we    = slot_ok(nbr_n);
        pv_waddr = slot_idx(nbr_n);
        pv_wdata = fresh;
      end
      CMD_D_RD: begin
        nx_re    = 1'b1;
        nx_raddr = slot_idx(anchor);
        pv_re    = 1'b1;
        pv_raddr = slot_idx(anchor);
        vs_re    = 1'b1;
        vs_raddr = slot_idx(anchor);
      end
      CMD_D_W1: begin
        // Unlink: predecessor skips to successor and back.
        nx_we    = slot_ok(pv_q);
        nx_waddr = slot_idx(pv_q);
        nx_wdata = nx_q;
        pv_we    = slot_ok(nx_q);
        pv_waddr = slot_idx(nx_q);
        pv_wdata = pv_q;
      end
      CMD_D_W2: begin
        nx_we    = 1'b1;
        nx_waddr = slot_idx(anchor);
        nx_wdata = free_s;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NULL_SLOT;
      tail     <= NULL_SLOT;
      free_s   <= '0;
      count    <= '0;
      init_idx <= '0;
    end else begin
      case (cmd)
        CMD_INIT: begin
          init_idx <= init_idx + IDX_W'(1);
        end
        CMD_ACCEPT: begin
          op_r  <= in_operation;
          pos_r <= in_position;
          val_r <= in_value;
        end
        CMD_DECODE: begin
          fresh  <= free_s;
          anchor <= dec_anchor;
          hops   <= dec_hops;
        end
        CMD_REJECT: begin
          res_status  <= dec_status;
          res_length  <= LEN_W'(count);
          res_removed <= '0;
        end
        CMD_I_POP: begin
          free_s <= nx_q;
        end
        CMD_WALK_START: begin
          hops <= hops - IDX_W'(1);
        end
        CMD_WALK_STEP: begin
          if (hops != '0) begin
            hops <= hops - IDX_W'(1);
          end else begin
            anchor <= nx_q;
          end
        end
        CMD_I_W1: begin
          nbr_n <= n_new;
        end
        CMD_I_W2: begin
          if (!slot_ok(anchor)) begin
            head <= fresh;
          end
          if (!slot_ok(nbr_n)) begin
            tail <= fresh;
          end
          count       <= count + SLOT_W'(1);
          res_status  <= ST_OK;
          res_length  <= LEN_W'(count + SLOT_W'(1));
          res_removed <= '0;
        end
        CMD_D_W1: begin
          if (!slot_ok(pv_q)) begin
            head <= nx_q;
          end
          if (!slot_ok(nx_q)) begin
            tail <= pv_q;
          end
        end
        CMD_D_W2: begin
          free_s      <= anchor;
          count       <= count - SLOT_W'(1);
          res_status  <= ST_OK;
          res_length  <= LEN_W'(count - SLOT_W'(1));
          res_removed <= vs_q;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bole_ctrl.sv -----
// Controller: sequences one request through the datapath and owns the handshakes.
`default_nettype none

module bole_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire bole_pkg::dp_status_t sts,
  output      bole_pkg::cmd_t       cmd
);
  import bole_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_REJECT,
    S_I_POP,
    S_WALK_START,
    S_WALK_STEP,
    S_I_RDN,
    S_I_W1,
    S_I_W2,
    S_D_RD,
    S_D_W1,
    S_D_W2
  } state_t;

  state_t state;
  state_t state_next;
  logic   ins_mode;
  logic   slot_free;
  logic   finish;

  // The result register may be overwritten once its beat is taken.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign finish    = slot_free &&
                     (state == S_REJECT || state == S_I_W2 || state == S_D_W2);

  always_comb begin
    cmd        = CMD_NOP;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd = CMD_INIT;
        if (sts.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd = CMD_DECODE;
        unique case (sts.kind)
          DEC_INS: state_next = S_I_POP;
          DEC_DEL: state_next = sts.dec_walk ? S_WALK_START : S_D_RD;
          default: state_next = S_REJECT;
        endcase
      end
      S_REJECT: begin
        if (slot_free) begin
          cmd        = CMD_REJECT;
          state_next = S_IDLE;
        end
      end
      S_I_POP: begin
        cmd        = CMD_I_POP;
        state_next = sts.hops_zero ? S_I_RDN : S_WALK_START;
      end
      S_WALK_START: begin
        cmd        = CMD_WALK_START;
        state_next = S_WALK_STEP;
      end
      S_WALK_STEP: begin
        cmd = CMD_WALK_STEP;
        if (sts.hops_zero) begin
          state_next = ins_mode ? S_I_RDN : S_D_RD;
        end
      end
      S_I_RDN: begin
        cmd        = CMD_I_RDN;
        state_next = S_I_W1;
      end
      S_I_W1: begin
        cmd        = CMD_I_W1;
        state_next = S_I_W2;
      end
      S_I_W2: begin
        if (slot_free) begin
          cmd        = CMD_I_W2;
          state_next = S_IDLE;
        end
      end
      S_D_RD: begin
        cmd        = CMD_D_RD;
        state_next = S_D_W1;
      end
      S_D_W1: begin
        cmd        = CMD_D_W1;
        state_next = S_D_W2;
      end
      S_D_W2: begin
        if (slot_free) begin
          cmd        = CMD_D_W2;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      ins_mode  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        ins_mode <= (sts.kind == DEC_INS);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine.
`default_nettype none

// The engine keeps up to CAPACITY (16) signed 32-bit values as a doubly
// linked list in three slot memories (next link, previous link, value), with
// unused slots chained on a free list. Each request beat inserts at the head,
// at the tail or at a 1-based position, or deletes at the head, at the tail or
// at a position, and answers with exactly one response beat that carries the
// status, the length after the request and, for a successful delete, the value
// taken out. Requests are handled one at a time, and the link walk of a
// positional request goes through the single read port of the next-link
// memory, one hop per cycle. The request side is ready again in the cycle
// after the response is loaded, even while that response beat still waits
// to be taken. After reset the engine builds the free chain through all
// CAPACITY slots (16) before it accepts its first request.
module bounded_ordered_list_engine (
  input wire logic clk,
  input wire logic rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);
  import bole_pkg::*;

  cmd_t       cmd;
  dp_status_t sts;

  // Controller: owns the state machine, the ready on the request side and the
  // valid of the response register.
  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: memories, list pointers, decode and the response payload.
  bole_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_operation (req.operation),
    .in_position  (req.position),
    .in_value     (req.value),
    .sts          (sts),
    .res_status   (rsp.status),
    .res_length   (rsp.length),
    .res_removed  (rsp.removed_value)
  );

endmodule

`default_nettype wire
